/* rtl/cpu_register_file_with_pairs_defines.svh */
// assertion macros used by the register file core
`ifndef CPU_REGISTER_FILE_WITH_PAIRS_DEFINES_SVH
`define CPU_REGISTER_FILE_WITH_PAIRS_DEFINES_SVH

`ifndef SYNTHESIS
`define CRFP_ASSERT_NEXT(lbl, cond, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error("crfp assertion failed");
`define CRFP_ASSERT_SAME(lbl, cond, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error("crfp assertion failed");
`else
`define CRFP_ASSERT_NEXT(lbl, cond, expr)
`define CRFP_ASSERT_SAME(lbl, cond, expr)
`endif

`endif

/* rtl/crfp_pkg.sv */
// shared types and codes of the cpu register file
package crfp_pkg;

    localparam logic [2:0] KIND_REG_READ  = 3'd0;
    localparam logic [2:0] KIND_REG_WRITE = 3'd1;
    localparam logic [2:0] KIND_FLAG_SET  = 3'd2;
    localparam logic [2:0] KIND_IO_READ   = 3'd3;
    localparam logic [2:0] KIND_IO_WRITE  = 3'd4;

    localparam logic [3:0] SEL_A  = 4'd0;
    localparam logic [3:0] SEL_B  = 4'd1;
    localparam logic [3:0] SEL_C  = 4'd2;
    localparam logic [3:0] SEL_D  = 4'd3;
    localparam logic [3:0] SEL_E  = 4'd4;
    localparam logic [3:0] SEL_F  = 4'd5;
    localparam logic [3:0] SEL_H  = 4'd6;
    localparam logic [3:0] SEL_L  = 4'd7;
    localparam logic [3:0] SEL_BC = 4'd8;
    localparam logic [3:0] SEL_DE = 4'd9;
    localparam logic [3:0] SEL_HL = 4'd10;
    localparam logic [3:0] SEL_AF = 4'd11;
    localparam logic [3:0] SEL_SP = 4'd12;
    localparam logic [3:0] SEL_PC = 4'd13;
    localparam logic [3:0] SEL_IE = 4'd14;

    localparam logic [1:0] FLAG_CLEAR = 2'd0;
    localparam logic [1:0] FLAG_SET   = 2'd1;

    localparam logic [15:0] ADDR_SERIAL_DATA = 16'hFF01;
    localparam logic [15:0] ADDR_SERIAL_CTRL = 16'hFF02;
    localparam logic [7:0]  FLAG_KEEP_MASK   = 8'hF0;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  reg_select;
        logic [15:0] value;
        logic [15:0] io_address;
        logic [1:0]  zero_update;
        logic [1:0]  subtract_update;
        logic [1:0]  half_carry_update;
        logic [1:0]  carry_update;
    } t_item;

    typedef struct packed {
        logic [15:0] read_data;
        logic        zero_flag;
        logic        subtract_flag;
        logic        half_carry_flag;
        logic        carry_flag;
    } t_result;

endpackage

/* rtl/cpu_register_file_with_pairs.sv */
// top level of the cpu register file with register pairs
// a request is held in the input register, then its result is registered in the result register
// throughput: one request per cycle while the result side keeps taking results
// all register and serial state is applied in the cycle a request moves to the result reg
// reset: synchronous active low i_rst_n clears the register file, the serial registers and both valid bits
module cpu_register_file_with_pairs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // reg_select[3:0], value[19:4], io_address[35:20], zero_update[37:36],
    // subtract_update[39:38], half_carry_update[41:40], carry_update[43:42]
    input  logic [47:0] s_axis_tdata,
    // kind[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[15:0], zero_flag[16], subtract_flag[17], half_carry_flag[18], carry_flag[19]
    output logic [23:0] m_axis_tdata
);

    logic              in_valid;
    logic              advance;
    crfp_pkg::t_item   item;
    crfp_pkg::t_result result;

    // move the held request into the core when the result slot frees up
    assign advance = in_valid && (!m_axis_tvalid || m_axis_tready);

    crfp_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_advance     (advance),
        .o_valid       (in_valid),
        .o_item        (item)
    );

    crfp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_item   (item),
        .o_result (result)
    );

    crfp_out_reg u_out_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (advance),
        .i_result      (result),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

/* rtl/crfp_in_reg.sv */
// input register stage: takes a request and holds it for the core
module crfp_in_reg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [crfp_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input  logic [2:0]                      s_axis_tuser,
    input  logic                            i_advance,
    output logic                            o_valid,
    output crfp_pkg::t_item                 o_item
);

    logic            r_valid;
    crfp_pkg::t_item r_item;
    crfp_pkg::t_item n_item;

    assign s_axis_tready = !r_valid || i_advance;

    always_comb begin
        n_item.kind              = s_axis_tuser;
        n_item.reg_select        = s_axis_tdata[3:0];
        n_item.value             = s_axis_tdata[19:4];
        n_item.io_address        = s_axis_tdata[35:20];
        n_item.zero_update       = s_axis_tdata[37:36];
        n_item.subtract_update   = s_axis_tdata[39:38];
        n_item.half_carry_update = s_axis_tdata[41:40];
        n_item.carry_update      = s_axis_tdata[43:42];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/crfp_core.sv */
// register storage, access decode and flag update
`include "cpu_register_file_with_pairs_defines.svh"

module crfp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  crfp_pkg::t_item   i_item,
    output crfp_pkg::t_result o_result
);

    logic [7:0]  r_a, r_b, r_c, r_d, r_e, r_f, r_h, r_l, r_ie, r_sd, r_sc;
    logic [15:0] r_sp, r_pc;
    logic [7:0]  n_a, n_b, n_c, n_d, n_e, n_f, n_h, n_l, n_ie, n_sd, n_sc;
    logic [15:0] n_sp, n_pc;
    logic [15:0] reg_rd;
    logic [15:0] read_data;
    logic [7:0]  lo;
    logic [7:0]  hi;

    function automatic logic apply_flag(input logic cur, input logic [1:0] action);
        logic res;
        case (action)
            crfp_pkg::FLAG_CLEAR: res = 1'b0;
            crfp_pkg::FLAG_SET:   res = 1'b1;
            default:              res = cur;
        endcase
        return res;
    endfunction

    assign lo = i_item.value[7:0];
    assign hi = i_item.value[15:8];

    always_comb begin
        case (i_item.reg_select)
            crfp_pkg::SEL_A:  reg_rd = {8'd0, r_a};
            crfp_pkg::SEL_B:  reg_rd = {8'd0, r_b};
            crfp_pkg::SEL_C:  reg_rd = {8'd0, r_c};
            crfp_pkg::SEL_D:  reg_rd = {8'd0, r_d};
            crfp_pkg::SEL_E:  reg_rd = {8'd0, r_e};
            crfp_pkg::SEL_F:  reg_rd = {8'd0, r_f};
            crfp_pkg::SEL_H:  reg_rd = {8'd0, r_h};
            crfp_pkg::SEL_L:  reg_rd = {8'd0, r_l};
            crfp_pkg::SEL_BC: reg_rd = {r_b, r_c};
            crfp_pkg::SEL_DE: reg_rd = {r_d, r_e};
            crfp_pkg::SEL_HL: reg_rd = {r_h, r_l};
            crfp_pkg::SEL_AF: reg_rd = {r_a, r_f};
            crfp_pkg::SEL_SP: reg_rd = r_sp;
            crfp_pkg::SEL_PC: reg_rd = r_pc;
            crfp_pkg::SEL_IE: reg_rd = {8'd0, r_ie};
            default:          reg_rd = 16'd0;
        endcase
    end

    always_comb begin
        n_a = r_a; n_b = r_b; n_c = r_c; n_d = r_d; n_e = r_e; n_f = r_f;
        n_h = r_h; n_l = r_l; n_sp = r_sp; n_pc = r_pc; n_ie = r_ie;
        n_sd = r_sd; n_sc = r_sc;
        read_data = 16'd0;
        case (i_item.kind)
            crfp_pkg::KIND_REG_READ: begin
                read_data = reg_rd;
            end
            crfp_pkg::KIND_REG_WRITE: begin
                case (i_item.reg_select)
                    crfp_pkg::SEL_A:  n_a = lo;
                    crfp_pkg::SEL_B:  n_b = lo;
                    crfp_pkg::SEL_C:  n_c = lo;
                    crfp_pkg::SEL_D:  n_d = lo;
                    crfp_pkg::SEL_E:  n_e = lo;
                    crfp_pkg::SEL_F:  n_f = lo;
                    crfp_pkg::SEL_H:  n_h = lo;
                    crfp_pkg::SEL_L:  n_l = lo;
                    crfp_pkg::SEL_BC: begin n_b = hi; n_c = lo; end
                    crfp_pkg::SEL_DE: begin n_d = hi; n_e = lo; end
                    crfp_pkg::SEL_HL: begin n_h = hi; n_l = lo; end
                    // low nibble of f is forced to zero on af pair writes
                    crfp_pkg::SEL_AF: begin n_a = hi; n_f = lo & crfp_pkg::FLAG_KEEP_MASK; end
                    crfp_pkg::SEL_SP: n_sp = i_item.value;
                    crfp_pkg::SEL_PC: n_pc = i_item.value;
                    crfp_pkg::SEL_IE: n_ie = lo;
                    default: ;
                endcase
            end
            crfp_pkg::KIND_FLAG_SET: begin
                n_f[7] = apply_flag(r_f[7], i_item.zero_update);
                n_f[6] = apply_flag(r_f[6], i_item.subtract_update);
                n_f[5] = apply_flag(r_f[5], i_item.half_carry_update);
                n_f[4] = apply_flag(r_f[4], i_item.carry_update);
            end
            crfp_pkg::KIND_IO_READ: begin
                if (i_item.io_address == crfp_pkg::ADDR_SERIAL_DATA) begin
                    read_data = {8'd0, r_sd};
                end else if (i_item.io_address == crfp_pkg::ADDR_SERIAL_CTRL) begin
                    read_data = {8'd0, r_sc};
                end
            end
            crfp_pkg::KIND_IO_WRITE: begin
                if (i_item.io_address == crfp_pkg::ADDR_SERIAL_DATA) begin
                    n_sd = lo;
                end else if (i_item.io_address == crfp_pkg::ADDR_SERIAL_CTRL) begin
                    n_sc = lo;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0; r_b <= '0; r_c <= '0; r_d <= '0; r_e <= '0; r_f <= '0;
            r_h <= '0; r_l <= '0; r_sp <= '0; r_pc <= '0; r_ie <= '0;
            r_sd <= '0; r_sc <= '0;
        end else if (i_load) begin
            r_a <= n_a; r_b <= n_b; r_c <= n_c; r_d <= n_d; r_e <= n_e; r_f <= n_f;
            r_h <= n_h; r_l <= n_l; r_sp <= n_sp; r_pc <= n_pc; r_ie <= n_ie;
            r_sd <= n_sd; r_sc <= n_sc;
        end
    end

    always_comb begin
        o_result.read_data       = read_data;
        o_result.zero_flag       = n_f[7];
        o_result.subtract_flag   = n_f[6];
        o_result.half_carry_flag = n_f[5];
        o_result.carry_flag      = n_f[4];
    end

    `CRFP_ASSERT_NEXT(a_af_write_clears_low, i_load && i_item.kind == crfp_pkg::KIND_REG_WRITE && i_item.reg_select == crfp_pkg::SEL_AF, r_f[3:0] == 4'd0)
    `CRFP_ASSERT_NEXT(a_io_keeps_flags, i_load && (i_item.kind == crfp_pkg::KIND_IO_READ || i_item.kind == crfp_pkg::KIND_IO_WRITE), $stable(r_f))
    `CRFP_ASSERT_NEXT(a_no_load_holds_sp, !i_load, $stable(r_sp) && $stable(r_pc))

endmodule

/* rtl/crfp_out_reg.sv */
// result register toward the master side
module crfp_out_reg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  crfp_pkg::t_result                i_result,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [crfp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic                             r_valid;
    logic [crfp_pkg::OUT_TDATA_W-1:0] r_data;
    logic [crfp_pkg::OUT_TDATA_W-1:0] n_data;

    assign n_data = {4'd0, i_result.carry_flag, i_result.half_carry_flag,
                     i_result.subtract_flag, i_result.zero_flag, i_result.read_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
        if (i_load) begin
            r_data <= n_data;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;

endmodule

/* verif/cpu_register_file_with_pairs_tb.sv */
// testbench for the cpu register file with register pairs
`timescale 1ns / 100ps

module cpu_register_file_with_pairs_tb;

    localparam logic [1:0] FLAG_KEEP     = 2'd2;
    localparam logic [1:0] FLAG_RESERVED = 2'd3;
    localparam logic [3:0] SEL_UNUSED    = 4'd15;
    localparam logic [2:0] KIND_UNUSED_5 = 3'd5;
    localparam logic [2:0] KIND_UNUSED_7 = 3'd7;
    localparam logic [15:0] ADDR_UNMAPPED = 16'hFF03;
    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT  = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;  // reg_select, value, io_address, z/n/h/c updates, zero pad
    logic [2:0]  s_axis_tuser;  // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;  // read_data, zero, subtract, half_carry, carry flags, zero pad

    // register file image kept by the testbench
    logic [7:0]  img_a, img_b, img_c, img_d, img_e, img_f, img_h, img_l;
    logic [15:0] img_sp, img_pc;
    logic [7:0]  img_ie;
    logic [7:0]  img_serial_data, img_serial_ctrl;

    crfp_pkg::t_result pending_results[$];
    int      error_count = 0;
    int      cycle_count = 0;
    bit      idle_on = 1'b1;

    cpu_register_file_with_pairs dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic next_flag(input logic cur, input logic [1:0] action);
        case (action)
            crfp_pkg::FLAG_CLEAR: return 1'b0;
            crfp_pkg::FLAG_SET:   return 1'b1;
            default:              return cur;
        endcase
    endfunction

    // applies one request to the image and returns what the block should answer
    function automatic crfp_pkg::t_result predict_access(input crfp_pkg::t_item req);
        crfp_pkg::t_result r;
        logic [7:0]        lo;
        logic [7:0]        hi;
        r  = '0;
        lo = req.value[7:0];
        hi = req.value[15:8];
        case (req.kind)
            crfp_pkg::KIND_REG_READ: begin
                case (req.reg_select)
                    crfp_pkg::SEL_A:  r.read_data = {8'h00, img_a};
                    crfp_pkg::SEL_B:  r.read_data = {8'h00, img_b};
                    crfp_pkg::SEL_C:  r.read_data = {8'h00, img_c};
                    crfp_pkg::SEL_D:  r.read_data = {8'h00, img_d};
                    crfp_pkg::SEL_E:  r.read_data = {8'h00, img_e};
                    crfp_pkg::SEL_F:  r.read_data = {8'h00, img_f};
                    crfp_pkg::SEL_H:  r.read_data = {8'h00, img_h};
                    crfp_pkg::SEL_L:  r.read_data = {8'h00, img_l};
                    crfp_pkg::SEL_BC: r.read_data = {img_b, img_c};
                    crfp_pkg::SEL_DE: r.read_data = {img_d, img_e};
                    crfp_pkg::SEL_HL: r.read_data = {img_h, img_l};
                    crfp_pkg::SEL_AF: r.read_data = {img_a, img_f};
                    crfp_pkg::SEL_SP: r.read_data = img_sp;
                    crfp_pkg::SEL_PC: r.read_data = img_pc;
                    crfp_pkg::SEL_IE: r.read_data = {8'h00, img_ie};
                    default:          r.read_data = 16'h0000;
                endcase
            end
            crfp_pkg::KIND_REG_WRITE: begin
                case (req.reg_select)
                    crfp_pkg::SEL_A:  img_a = lo;
                    crfp_pkg::SEL_B:  img_b = lo;
                    crfp_pkg::SEL_C:  img_c = lo;
                    crfp_pkg::SEL_D:  img_d = lo;
                    crfp_pkg::SEL_E:  img_e = lo;
                    crfp_pkg::SEL_F:  img_f = lo;
                    crfp_pkg::SEL_H:  img_h = lo;
                    crfp_pkg::SEL_L:  img_l = lo;
                    crfp_pkg::SEL_BC: begin
                        img_b = hi;
                        img_c = lo;
                    end
                    crfp_pkg::SEL_DE: begin
                        img_d = hi;
                        img_e = lo;
                    end
                    crfp_pkg::SEL_HL: begin
                        img_h = hi;
                        img_l = lo;
                    end
                    // low nibble of f is cleared when written through the pair
                    crfp_pkg::SEL_AF: begin
                        img_a = hi;
                        img_f = lo & crfp_pkg::FLAG_KEEP_MASK;
                    end
                    crfp_pkg::SEL_SP: img_sp = req.value;
                    crfp_pkg::SEL_PC: img_pc = req.value;
                    crfp_pkg::SEL_IE: img_ie = lo;
                    default: ;
                endcase
            end
            crfp_pkg::KIND_FLAG_SET: begin
                img_f[7] = next_flag(img_f[7], req.zero_update);
                img_f[6] = next_flag(img_f[6], req.subtract_update);
                img_f[5] = next_flag(img_f[5], req.half_carry_update);
                img_f[4] = next_flag(img_f[4], req.carry_update);
            end
            crfp_pkg::KIND_IO_READ: begin
                if (req.io_address == crfp_pkg::ADDR_SERIAL_DATA)
                    r.read_data = {8'h00, img_serial_data};
                else if (req.io_address == crfp_pkg::ADDR_SERIAL_CTRL)
                    r.read_data = {8'h00, img_serial_ctrl};
            end
            crfp_pkg::KIND_IO_WRITE: begin
                if (req.io_address == crfp_pkg::ADDR_SERIAL_DATA)
                    img_serial_data = lo;
                else if (req.io_address == crfp_pkg::ADDR_SERIAL_CTRL)
                    img_serial_ctrl = lo;
            end
            default: ;
        endcase
        r.zero_flag       = img_f[7];
        r.subtract_flag   = img_f[6];
        r.half_carry_flag = img_f[5];
        r.carry_flag      = img_f[4];
        return r;
    endfunction

    function automatic crfp_pkg::t_item make_item(input logic [2:0] kind,
                                                  input logic [3:0] sel,
                                                  input logic [15:0] value,
                                                  input logic [15:0] addr,
                                                  input logic [1:0] z, input logic [1:0] n,
                                                  input logic [1:0] h, input logic [1:0] c);
        crfp_pkg::t_item req;
        req.kind              = kind;
        req.reg_select        = sel;
        req.value             = value;
        req.io_address        = addr;
        req.zero_update       = z;
        req.subtract_update   = n;
        req.half_carry_update = h;
        req.carry_update      = c;
        return req;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
        error_count++;
    endtask

    // drives one request, called at a clock edge, returns at the edge it is taken
    task automatic send_request(input crfp_pkg::t_item req);
        int gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req.kind;
        s_axis_tdata  <= {4'h0, req.carry_update, req.half_carry_update,
                          req.subtract_update, req.zero_update,
                          req.io_address, req.value, req.reg_select};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(predict_access(req));
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // result side: random stall before each result
    initial begin : result_sink
        int stall;
        m_axis_tready = 1'b0;
        forever begin
            stall = idle_on ? $urandom_range(0, 9) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    always @(posedge i_clk) begin : result_check
        crfp_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending", m_axis_tdata[15:0], 16'h0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[15:0] !== want.read_data)
                    report_mismatch("read_data", m_axis_tdata[15:0], want.read_data);
                if (m_axis_tdata[16] !== want.zero_flag)
                    report_mismatch("zero_flag", {15'd0, m_axis_tdata[16]},
                                    {15'd0, want.zero_flag});
                if (m_axis_tdata[17] !== want.subtract_flag)
                    report_mismatch("subtract_flag", {15'd0, m_axis_tdata[17]},
                                    {15'd0, want.subtract_flag});
                if (m_axis_tdata[18] !== want.half_carry_flag)
                    report_mismatch("half_carry_flag", {15'd0, m_axis_tdata[18]},
                                    {15'd0, want.half_carry_flag});
                if (m_axis_tdata[19] !== want.carry_flag)
                    report_mismatch("carry_flag", {15'd0, m_axis_tdata[19]},
                                    {15'd0, want.carry_flag});
            end
        end
    end

    task automatic test_register_pairs();
        send_request(make_item(crfp_pkg::KIND_REG_WRITE, crfp_pkg::SEL_AF, 16'hFFFF, 16'h0000,
                               2'd0, 2'd0, 2'd0, 2'd0));
        send_request(make_item(crfp_pkg::KIND_REG_READ, crfp_pkg::SEL_AF, 16'h0000, 16'h0000,
                               2'd0, 2'd0, 2'd0, 2'd0));
        send_request(make_item(crfp_pkg::KIND_REG_READ, crfp_pkg::SEL_F, 16'h0000, 16'h0000,
                               2'd0, 2'd0, 2'd0, 2'd0));
        // f written alone keeps its low nibble
        send_request(make_item(crfp_pkg::KIND_REG_WRITE, crfp_pkg::SEL_F, 16'hFF0F, 16'h0000,
                               2'd0, 2'd0, 2'd0, 2'd0));
        send_request(make_item(crfp_pkg::KIND_REG_READ, crfp_pkg::SEL_F, 16'h0000, 16'h0000,
                               2'd0, 2'd0, 2'd0, 2'd0));
        send_request(make_item(crfp_pkg::KIND_REG_WRITE, crfp_pkg::SEL_HL, 16'hFF00, 16'h0000,
                               2'd0, 2'd0, 2'd0, 2'd0));
        send_request(make_item(crfp_pkg::KIND_REG_READ, crfp_pkg::SEL_HL, 16'h0000, 16'h0000,
                               2'd0, 2'd0, 2'd0, 2'd0));
        send_request(make_item(crfp_pkg::KIND_REG_READ, crfp_pkg::SEL_L, 16'h0000, 16'h0000,
                               2'd0, 2'd0, 2'd0, 2'd0));
        send_request(make_item(crfp_pkg::KIND_REG_WRITE, crfp_pkg::SEL_IE, 16'hFFFF, 16'h0000,
                               2'd0, 2'd0, 2'd0, 2'd0));
        send_request(make_item(crfp_pkg::KIND_REG_READ, crfp_pkg::SEL_IE, 16'h0000, 16'h0000,
                               2'd0, 2'd0, 2'd0, 2'd0));
        send_request(make_item(crfp_pkg::KIND_REG_WRITE, crfp_pkg::SEL_SP, 16'hFFFF, 16'h0000,
                               2'd0, 2'd0, 2'd0, 2'd0));
        send_request(make_item(crfp_pkg::KIND_REG_READ, crfp_pkg::SEL_SP, 16'h0000, 16'h0000,
                               2'd0, 2'd0, 2'd0, 2'd0));
        send_request(make_item(crfp_pkg::KIND_REG_WRITE, SEL_UNUSED, 16'hFFFF, 16'h0000,
                               2'd0, 2'd0, 2'd0, 2'd0));
        send_request(make_item(crfp_pkg::KIND_REG_READ, SEL_UNUSED, 16'h0000, 16'h0000,
                               2'd0, 2'd0, 2'd0, 2'd0));
    endtask

    task automatic test_flag_updates();
        send_request(make_item(crfp_pkg::KIND_FLAG_SET, crfp_pkg::SEL_A, 16'h0000, 16'h0000,
                               crfp_pkg::FLAG_CLEAR, crfp_pkg::FLAG_CLEAR,
                               crfp_pkg::FLAG_CLEAR, crfp_pkg::FLAG_CLEAR));
        send_request(make_item(crfp_pkg::KIND_FLAG_SET, crfp_pkg::SEL_A, 16'h0000, 16'h0000,
                               crfp_pkg::FLAG_SET, crfp_pkg::FLAG_SET,
                               crfp_pkg::FLAG_SET, crfp_pkg::FLAG_SET));
        send_request(make_item(crfp_pkg::KIND_FLAG_SET, crfp_pkg::SEL_A, 16'h0000, 16'h0000,
                               FLAG_KEEP, crfp_pkg::FLAG_CLEAR,
                               FLAG_KEEP, crfp_pkg::FLAG_CLEAR));
        // reserved action behaves as keep
        send_request(make_item(crfp_pkg::KIND_FLAG_SET, crfp_pkg::SEL_A, 16'h0000, 16'h0000,
                               FLAG_RESERVED, FLAG_RESERVED, FLAG_RESERVED, FLAG_RESERVED));
    endtask

    task automatic test_serial_io();
        send_request(make_item(crfp_pkg::KIND_IO_WRITE, crfp_pkg::SEL_A, 16'hFFA5,
                               crfp_pkg::ADDR_SERIAL_DATA, 2'd0, 2'd0, 2'd0, 2'd0));
        send_request(make_item(crfp_pkg::KIND_IO_WRITE, crfp_pkg::SEL_A, 16'h005A,
                               crfp_pkg::ADDR_SERIAL_CTRL, 2'd0, 2'd0, 2'd0, 2'd0));
        send_request(make_item(crfp_pkg::KIND_IO_WRITE, crfp_pkg::SEL_A, 16'hFFFF,
                               ADDR_UNMAPPED, 2'd0, 2'd0, 2'd0, 2'd0));
        send_request(make_item(crfp_pkg::KIND_IO_READ, crfp_pkg::SEL_A, 16'h0000,
                               crfp_pkg::ADDR_SERIAL_DATA, 2'd0, 2'd0, 2'd0, 2'd0));
        send_request(make_item(crfp_pkg::KIND_IO_READ, crfp_pkg::SEL_A, 16'h0000,
                               crfp_pkg::ADDR_SERIAL_CTRL, 2'd0, 2'd0, 2'd0, 2'd0));
        send_request(make_item(crfp_pkg::KIND_IO_READ, crfp_pkg::SEL_A, 16'h0000,
                               16'hFFFF, 2'd0, 2'd0, 2'd0, 2'd0));
        send_request(make_item(KIND_UNUSED_7, crfp_pkg::SEL_AF, 16'hFFFF,
                               crfp_pkg::ADDR_SERIAL_DATA,
                               crfp_pkg::FLAG_SET, crfp_pkg::FLAG_SET,
                               crfp_pkg::FLAG_SET, crfp_pkg::FLAG_SET));
    endtask

    task automatic test_random_traffic(input int count);
        crfp_pkg::t_item req;
        for (int i = 0; i < count; i++) begin
            // a stretch at full rate on both sides
            idle_on = !(i >= 200 && i < 280);
            if (i == 300)
                wait_for_results();
            if ($urandom_range(0, 19) == 0)
                req.kind = 3'($urandom_range(KIND_UNUSED_5, KIND_UNUSED_7));
            else
                req.kind = 3'($urandom_range(crfp_pkg::KIND_REG_READ,
                                             crfp_pkg::KIND_IO_WRITE));
            req.reg_select = 4'($urandom_range(0, 15));
            req.value      = 16'($urandom_range(0, 65535));
            // half of the time a serial address so io requests hit real storage
            case ($urandom_range(0, 3))
                0:       req.io_address = crfp_pkg::ADDR_SERIAL_DATA;
                1:       req.io_address = crfp_pkg::ADDR_SERIAL_CTRL;
                default: req.io_address = 16'($urandom_range(0, 65535));
            endcase
            req.zero_update       = 2'($urandom_range(0, 3));
            req.subtract_update   = 2'($urandom_range(0, 3));
            req.half_carry_update = 2'($urandom_range(0, 3));
            req.carry_update      = 2'($urandom_range(0, 3));
            send_request(req);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        {img_a, img_b, img_c, img_d, img_e, img_f, img_h, img_l} = '0;
        img_sp          = '0;
        img_pc          = '0;
        img_ie          = '0;
        img_serial_data = '0;
        img_serial_ctrl = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_register_pairs();
        test_flag_updates();
        test_serial_io();
        test_random_traffic(RANDOM_ITEMS);
        wait_for_results();

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
